// File: hw/rtl/cws_pkg.sv
// Shared types and constants for the congestion window sender.
// No dependencies; used by the timer cell, the divider and the top level.
`default_nettype none
package cws_pkg;
   localparam int QUEUE_DEPTH = 64;
   localparam int SEQ_BITS    = 24;
   localparam int QIDX_BITS   = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);
   localparam int STAMP_BITS  = 32;
   localparam int SIZE_BITS   = 16;
   localparam int SPAN_BITS   = 32;
   localparam int PROD_BITS   = 2 * SIZE_BITS;
   localparam int DIV_STEPS   = PROD_BITS;
   localparam int DCNT_BITS   = $clog2(DIV_STEPS + 1);

   localparam logic [SIZE_BITS-1:0] SEG_SIZE_RESET  = SIZE_BITS'(1000);
   localparam logic [SEQ_BITS-1:0]  LAST_BYTE_RESET = SEQ_BITS'(99999);
   localparam logic [SPAN_BITS-1:0] SPAN_RESET      = SPAN_BITS'(1000000);
   localparam logic [SEQ_BITS-1:0]  SEQ_MAX         = {SEQ_BITS{1'b1}};

   localparam logic [1:0] CSR_SEG_SIZE  = 2'd0;
   localparam logic [1:0] CSR_LAST_BYTE = 2'd1;
   localparam logic [1:0] CSR_TIMEOUT   = 2'd2;

   typedef struct packed {
      logic shift;
      logic load;
   } cell_ctl_type;
endpackage
`default_nettype wire

// File: hw/rtl/cws_timer_cell.sv
// One timer slot of the queue chain: holds a sequence number and time stamp.
// Depends on cws_pkg.
`default_nettype none
module cws_timer_cell (
   input  wire logic                                 clock,
   input  wire cws_pkg::cell_ctl_type                ctl,
   input  wire logic [cws_pkg::SEQ_BITS-1:0]         next_seq,
   input  wire logic [cws_pkg::STAMP_BITS-1:0]       next_stamp,
   input  wire logic [cws_pkg::SEQ_BITS-1:0]         new_seq,
   input  wire logic [cws_pkg::STAMP_BITS-1:0]       new_stamp,
   output logic [cws_pkg::SEQ_BITS-1:0]              seq,
   output logic [cws_pkg::STAMP_BITS-1:0]            stamp
);
   logic [cws_pkg::SEQ_BITS-1:0]   seq_ff, seq_in;
   logic [cws_pkg::STAMP_BITS-1:0] stamp_ff, stamp_in;

   always_comb begin
      seq_in   = seq_ff;
      stamp_in = stamp_ff;
      if (ctl.load) begin
         seq_in   = new_seq;
         stamp_in = new_stamp;
      end else if (ctl.shift) begin
         seq_in   = next_seq;
         stamp_in = next_stamp;
      end
   end

   always_ff @(posedge clock) begin
      seq_ff   <= seq_in;
      stamp_ff <= stamp_in;
   end

   assign seq   = seq_ff;
   assign stamp = stamp_ff;
endmodule
`default_nettype wire

// File: hw/rtl/cws_divider.sv
// Restoring divider, one quotient bit per cycle, for the window increase.
// Depends on cws_pkg.
`default_nettype none
module cws_divider (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   input  wire logic [cws_pkg::PROD_BITS-1:0]      dividend,
   input  wire logic [cws_pkg::SEQ_BITS-1:0]       divisor,
   output logic                                    done,
   output logic [cws_pkg::PROD_BITS-1:0]           quotient
);
   logic [cws_pkg::PROD_BITS-1:0] quo_ff, quo_in;
   logic [cws_pkg::SEQ_BITS:0]    rem_ff, rem_in;
   logic [cws_pkg::SEQ_BITS-1:0]  dvs_ff, dvs_in;
   logic [cws_pkg::DCNT_BITS-1:0] cnt_ff, cnt_in;
   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [cws_pkg::SEQ_BITS+1:0]  trial;
   logic [cws_pkg::SEQ_BITS+1:0]  shifted;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff, quo_ff[cws_pkg::PROD_BITS-1]};
      trial   = shifted - {2'b00, dvs_ff};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = cws_pkg::DCNT_BITS'(cws_pkg::DIV_STEPS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[cws_pkg::SEQ_BITS+1]) begin
            rem_in = trial[cws_pkg::SEQ_BITS:0];
            quo_in = {quo_ff[cws_pkg::PROD_BITS-2:0], 1'b1};
         end else begin
            rem_in = shifted[cws_pkg::SEQ_BITS:0];
            quo_in = {quo_ff[cws_pkg::PROD_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - cws_pkg::DCNT_BITS'(1);
         if (cnt_ff == cws_pkg::DCNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule
`default_nettype wire

// File: hw/rtl/congestion_window_sender_unit.sv
// Top level of the congestion window sender: control sequencer, timer chain,
// window divider. Depends on cws_pkg, cws_timer_cell and cws_divider.
//
// Usage: each req_ item is one pass of the sender loop (command, ack_number,
// now_time). Exactly one rsp_ item comes back per req_ item, in order.
// csr_ writes set segment_size (0), last_byte (1), timeout_span (2); csr_ready
// is always high; write only while no item is in work.
// Flow: a poll or stale ack goes from IDLE through DIV_START and CHECK to
// SEND, which loads the output register; once done, CHECK is skipped. A new
// ack adds DIV_WAIT for the window division (one quotient bit per cycle, 32
// bits) and PRUNE to drop acked timers; the timer chain shifts one slot per
// cycle toward its head. One item is in work at a time; req_stall is high
// while it runs, so a new item is accepted only once the last leaves SEND.
// A finished item sits in the output register while rsp_stall is high; the
// next item may be accepted meanwhile and waits before its result stage.
// Reset (synchronous, active high) empties the timer chain, sets the window
// to 1000, clears ack and next sequence, and restores register defaults.
// Timer slot contents are undefined until written; occupancy is a count.
`default_nettype none
module congestion_window_sender_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic                              req_command,
   input  wire logic [23:0]                       req_ack_number,
   input  wire logic [31:0]                       req_now_time,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic                                   rsp_send_valid,
   output logic [23:0]                            rsp_send_seq,
   output logic [23:0]                            rsp_window_now,
   output logic [23:0]                            rsp_acked_up_to,
   output logic                                   rsp_timeout_fired,
   output logic                                   rsp_done_res,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [1:0]                        csr_index,
   input  wire logic [31:0]                       csr_data
);
   localparam int SB = cws_pkg::SEQ_BITS;
   localparam int QD = cws_pkg::QUEUE_DEPTH;

   typedef enum logic [2:0] {
      ST_IDLE, ST_DIV_START, ST_DIV_WAIT, ST_PRUNE, ST_CHECK, ST_SEND
   } state_type;

   state_type                        state_ff, state_in;
   logic [cws_pkg::SIZE_BITS-1:0]    seg_size_ff, seg_size_in;
   logic [SB-1:0]                    last_byte_ff, last_byte_in;
   logic [cws_pkg::SPAN_BITS-1:0]    span_ff, span_in;
   logic [SB-1:0]                    window_ff, window_in;
   logic [SB-1:0]                    highest_ff, highest_in;
   logic [SB-1:0]                    next_seq_ff, next_seq_in;
   logic [cws_pkg::CNT_BITS-1:0]     count_ff, count_in;
   logic [SB-1:0]                    ack_ff, ack_in;
   logic [cws_pkg::STAMP_BITS-1:0]   now_ff, now_in;
   logic                             cmd_ff, cmd_in;
   logic                             frozen_ff, frozen_in;
   logic                             fired_ff, fired_in;
   logic [cws_pkg::PROD_BITS-1:0]    prod_ff, prod_in;
   logic                             ov_ff, ov_in;
   logic                             o_send_ff, o_send_in;
   logic [SB-1:0]                    o_seq_ff, o_seq_in;
   logic [SB-1:0]                    o_win_ff, o_win_in;
   logic [SB-1:0]                    o_ack_ff, o_ack_in;
   logic                             o_fired_ff, o_fired_in;
   logic                             o_done_ff, o_done_in;

   cws_pkg::cell_ctl_type            cell_ctl [QD];
   logic [SB-1:0]                    cell_seq [QD+1];
   logic [cws_pkg::STAMP_BITS-1:0]   cell_stamp [QD+1];
   logic                             do_shift, do_append;

   logic                             div_start, div_done;
   logic [cws_pkg::PROD_BITS-1:0]    div_quo;
   logic [SB-1:0]                    div_dvs;

   logic [SB:0]                      head_end, send_end, send_lim, seq_step;
   logic [cws_pkg::PROD_BITS:0]      grown;
   logic [cws_pkg::STAMP_BITS-1:0]   elapsed;
   logic                             can_send, out_free;

   assign cell_seq[QD]   = '0;
   assign cell_stamp[QD] = '0;

   for (genvar i = 0; i < QD; i++) begin : g_cell
      always_comb begin
         cell_ctl[i].shift = do_shift;
         cell_ctl[i].load  = do_append &&
                             (count_ff[cws_pkg::QIDX_BITS-1:0] ==
                              cws_pkg::QIDX_BITS'(i));
      end
      cws_timer_cell u_cell (
         .clock      (clock),
         .ctl        (cell_ctl[i]),
         .next_seq   (cell_seq[i+1]),
         .next_stamp (cell_stamp[i+1]),
         .new_seq    (next_seq_ff),
         .new_stamp  (now_ff),
         .seq        (cell_seq[i]),
         .stamp      (cell_stamp[i])
      );
   end

   assign div_dvs = (window_ff == '0) ? SB'(1) : window_ff;

   cws_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_ff),
      .divisor  (div_dvs),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_comb begin
      head_end = {1'b0, cell_seq[0]} + {{(SB+1-cws_pkg::SIZE_BITS){1'b0}}, seg_size_ff};
      send_end = {1'b0, next_seq_ff} + {{(SB+1-cws_pkg::SIZE_BITS){1'b0}}, seg_size_ff};
      send_lim = {1'b0, window_ff} + {1'b0, highest_ff};
      seq_step = send_end;
      grown    = {{(cws_pkg::PROD_BITS+1-SB){1'b0}}, window_ff} + {1'b0, div_quo};
      elapsed  = now_ff - cell_stamp[0];
      can_send = (send_end <= send_lim) && (next_seq_ff < last_byte_ff) &&
                 (count_ff < cws_pkg::CNT_BITS'(QD));
      out_free = !ov_ff || !rsp_stall;
   end

   always_comb begin
      state_in     = state_ff;
      seg_size_in  = seg_size_ff;
      last_byte_in = last_byte_ff;
      span_in      = span_ff;
      window_in    = window_ff;
      highest_in   = highest_ff;
      next_seq_in  = next_seq_ff;
      count_in     = count_ff;
      ack_in       = ack_ff;
      now_in       = now_ff;
      cmd_in       = cmd_ff;
      frozen_in    = frozen_ff;
      fired_in     = fired_ff;
      prod_in      = prod_ff;
      ov_in        = ov_ff && rsp_stall;
      o_send_in    = o_send_ff;
      o_seq_in     = o_seq_ff;
      o_win_in     = o_win_ff;
      o_ack_in     = o_ack_ff;
      o_fired_in   = o_fired_ff;
      o_done_in    = o_done_ff;
      do_shift     = 1'b0;
      do_append    = 1'b0;
      div_start    = 1'b0;

      if (csr_valid) begin
         case (csr_index)
            cws_pkg::CSR_SEG_SIZE:  seg_size_in  = csr_data[cws_pkg::SIZE_BITS-1:0];
            cws_pkg::CSR_LAST_BYTE: last_byte_in = csr_data[SB-1:0];
            cws_pkg::CSR_TIMEOUT:   span_in      = csr_data[cws_pkg::SPAN_BITS-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in    = req_command;
               ack_in    = req_ack_number;
               now_in    = req_now_time;
               frozen_in = highest_ff > last_byte_ff;
               fired_in  = 1'b0;
               prod_in   = cws_pkg::PROD_BITS'(seg_size_ff) *
                           cws_pkg::PROD_BITS'(seg_size_ff);
               state_in  = ST_DIV_START;
            end
         end
         ST_DIV_START: begin
            if (!frozen_ff && cmd_ff && (ack_ff > highest_ff)) begin
               highest_in = ack_ff;
               div_start  = 1'b1;
               state_in   = ST_DIV_WAIT;
            end else begin
               state_in = frozen_ff ? ST_SEND : ST_CHECK;
            end
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               window_in = (grown > {{(cws_pkg::PROD_BITS+1-SB){1'b0}}, cws_pkg::SEQ_MAX}) ?
                           cws_pkg::SEQ_MAX : grown[SB-1:0];
               state_in  = ST_PRUNE;
            end
         end
         ST_PRUNE: begin
            if ((count_ff != '0) && (head_end <= {1'b0, highest_ff})) begin
               do_shift = 1'b1;
               count_in = count_ff - cws_pkg::CNT_BITS'(1);
            end else begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if ((count_ff != '0) && (elapsed > span_ff)) begin
               fired_in    = 1'b1;
               count_in    = '0;
               window_in   = {{(SB-cws_pkg::SIZE_BITS){1'b0}}, seg_size_ff};
               next_seq_in = highest_ff;
            end
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (out_free) begin
               o_send_in  = 1'b0;
               o_seq_in   = '0;
               o_fired_in = fired_ff;
               o_win_in   = window_ff;
               o_ack_in   = highest_ff;
               o_done_in  = highest_ff > last_byte_ff;
               if (!frozen_ff && can_send) begin
                  do_append   = 1'b1;
                  o_send_in   = 1'b1;
                  o_seq_in    = next_seq_ff;
                  count_in    = count_ff + cws_pkg::CNT_BITS'(1);
                  next_seq_in = seq_step[SB] ? cws_pkg::SEQ_MAX : seq_step[SB-1:0];
               end
               ov_in    = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      ack_ff     <= ack_in;
      now_ff     <= now_in;
      cmd_ff     <= cmd_in;
      frozen_ff  <= frozen_in;
      fired_ff   <= fired_in;
      prod_ff    <= prod_in;
      o_send_ff  <= o_send_in;
      o_seq_ff   <= o_seq_in;
      o_win_ff   <= o_win_in;
      o_ack_ff   <= o_ack_in;
      o_fired_ff <= o_fired_in;
      o_done_ff  <= o_done_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         seg_size_ff  <= cws_pkg::SEG_SIZE_RESET;
         last_byte_ff <= cws_pkg::LAST_BYTE_RESET;
         span_ff      <= cws_pkg::SPAN_RESET;
         window_ff    <= {{(SB-cws_pkg::SIZE_BITS){1'b0}}, cws_pkg::SEG_SIZE_RESET};
         highest_ff   <= '0;
         next_seq_ff  <= '0;
         count_ff     <= '0;
         ov_ff        <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seg_size_ff  <= seg_size_in;
         last_byte_ff <= last_byte_in;
         span_ff      <= span_in;
         window_ff    <= window_in;
         highest_ff   <= highest_in;
         next_seq_ff  <= next_seq_in;
         count_ff     <= count_in;
         ov_ff        <= ov_in;
      end
   end

   assign req_stall         = (state_ff != ST_IDLE);
   assign csr_ready         = 1'b1;
   assign rsp_valid         = ov_ff;
   assign rsp_send_valid    = o_send_ff;
   assign rsp_send_seq      = o_seq_ff;
   assign rsp_window_now    = o_win_ff;
   assign rsp_acked_up_to   = o_ack_ff;
   assign rsp_timeout_fired = o_fired_ff;
   assign rsp_done_res      = o_done_ff;
endmodule
`default_nettype wire

// File: hw/rtl/cws_port_checker.sv
// Port-level assertions for the congestion window sender, bound to the top.
// Depends on congestion_window_sender_unit's port list only.
`default_nettype none
module cws_port_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic        rsp_send_valid,
   input wire logic [23:0] rsp_send_seq,
   input wire logic [23:0] rsp_acked_up_to
);
   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   a_seq_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_send_valid |-> rsp_send_seq == 24'd0)
      else $error("sequence nonzero without a send");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("reset did not clear the channels");

   a_ack_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_acked_up_to))
      else $error("acknowledged point moved while stalled");
endmodule

bind congestion_window_sender_unit cws_port_checker u_cws_port_checker (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_send_valid  (rsp_send_valid),
   .rsp_send_seq    (rsp_send_seq),
   .rsp_acked_up_to (rsp_acked_up_to)
);
`default_nettype wire
